// ===== hdl/signed_number_to_digit_writes_assert.svh =====
// Assertion macros used by the checker of the digit write block.
`ifndef SIGNED_NUMBER_TO_DIGIT_WRITES_ASSERT_SVH
`define SIGNED_NUMBER_TO_DIGIT_WRITES_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SNTDW_ASSERT_IMP(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SNTDW_ASSERT_NXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== hdl/sntdw_pkg.sv =====
// Types and constants for the signed number to digit write block.
`timescale 1ns / 1ps

package sntdw_pkg;

  localparam int NumDigits = 4;

  // Shown range of the signed input.
  localparam logic signed [15:0] NumMax = 16'sd9999;
  localparam logic signed [15:0] NumMin = -16'sd999;

  // Magnitude never exceeds 9999.
  localparam int MagW  = 14;
  localparam int ProdW = 2 * MagW;

  // floor(mag / d) == (mag * Recip) >> Shift for every mag up to 9999.
  localparam logic [MagW-1:0] Recip1000 = 14'd8389;
  localparam int              Shift1000 = 23;
  localparam logic [MagW-1:0] Recip100  = 14'd5243;
  localparam int              Shift100  = 19;
  localparam logic [MagW-1:0] Recip10   = 14'd6554;
  localparam int              Shift10   = 16;

  typedef logic [MagW-1:0] mag_t;
  typedef logic [3:0]      digit_t;
  typedef logic [2:0]      dreg_t;

  localparam digit_t CodeBlank = 4'd15;
  localparam digit_t CodeMinus = 4'd10;
  localparam dreg_t  FirstReg  = 3'd1;

  // Sign and magnitude of an in-range number.
  typedef struct packed {
    logic neg;
    mag_t mag;
  } num_t;

  // Number with its truncated quotients by 1000, 100 and 10.
  typedef struct packed {
    logic       neg;
    mag_t       mag;
    logic [3:0] q1000;
    logic [6:0] q100;
    logic [9:0] q10;
  } quot_t;

endpackage

// ===== hdl/signed_number_to_digit_writes.sv =====
// Top level: signed number in, four display digit-register writes out.
`timescale 1ns / 1ps

// Each accepted 16-bit signed number in -999..9999 becomes four writes to
// digit registers 1..4 (leftmost first), with leading zeros blanked (code 15),
// a minus sign (code 10) just left of the leading digit, and tlast on the
// fourth write. Numbers outside that range are accepted and give no writes.
// The path is three registers deep: input/abs, reciprocal quotients, and the
// digit buffer, and each write is presented from that digit buffer.
// The four writes leave the single digit buffer one per cycle while out_tready
// is high, and the buffer loads the next number as its last write is taken; an
// out-of-range number is dropped at the input register. A new number is taken
// while earlier ones are in flight.
module signed_number_to_digit_writes (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] number_in
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [2:0] digit_register, [6:3] digit_code, [7] zero
  output logic        out_tlast   // last_write
);
  import sntdw_pkg::*;

  logic   num_valid, num_ready;
  num_t   num;
  logic   quot_valid, quot_ready;
  quot_t  quot;
  dreg_t  digit_register;
  digit_t digit_code;

  sntdw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_number (signed'(in_tdata)),
    .out_valid (num_valid),
    .out_ready (num_ready),
    .out_num   (num)
  );

  sntdw_quot u_quot (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (num_valid),
    .in_ready  (num_ready),
    .in_num    (num),
    .out_valid (quot_valid),
    .out_ready (quot_ready),
    .out_quot  (quot)
  );

  sntdw_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (quot_valid),
    .in_ready  (quot_ready),
    .in_quot   (quot),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_reg   (digit_register),
    .out_code  (digit_code),
    .out_last  (out_tlast)
  );

  assign out_tdata = {1'b0, digit_code, digit_register};

endmodule

// ===== hdl/sntdw_front.sv =====
// Input register: range check, sign split and absolute value.
`timescale 1ns / 1ps

module sntdw_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_number,
  output logic               out_valid,
  input  logic               out_ready,
  output sntdw_pkg::num_t    out_num
);
  import sntdw_pkg::*;

  logic        valid_r, valid_nxt;
  num_t        num_r;
  logic        in_range;
  logic        neg;
  logic [15:0] abs_w;

  always_comb begin
    in_ready  = !valid_r || out_ready;
    in_range  = (in_number <= NumMax) && (in_number >= NumMin);
    neg       = in_number[15];
    abs_w     = neg ? 16'(-in_number) : 16'(in_number);
    // drop an out-of-range request right here
    valid_nxt = in_ready ? (in_valid && in_range) : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      num_r.neg <= neg;
      num_r.mag <= abs_w[MagW-1:0];
    end
  end

  assign out_valid = valid_r;
  assign out_num   = num_r;

endmodule

// ===== hdl/sntdw_quot.sv =====
// Quotient stage: magnitude divided by 1000, 100 and 10 via reciprocal products.
`timescale 1ns / 1ps

module sntdw_quot (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  sntdw_pkg::num_t  in_num,
  output logic             out_valid,
  input  logic             out_ready,
  output sntdw_pkg::quot_t out_quot
);
  import sntdw_pkg::*;

  logic             valid_r, valid_nxt;
  quot_t            quot_r;
  logic [ProdW-1:0] p1000, p100, p10;
  quot_t            quot_nxt;

  always_comb begin
    p1000 = ProdW'(in_num.mag) * ProdW'(Recip1000);
    p100  = ProdW'(in_num.mag) * ProdW'(Recip100);
    p10   = ProdW'(in_num.mag) * ProdW'(Recip10);

    quot_nxt.neg   = in_num.neg;
    quot_nxt.mag   = in_num.mag;
    quot_nxt.q1000 = 4'(p1000 >> Shift1000);
    quot_nxt.q100  = 7'(p100 >> Shift100);
    quot_nxt.q10   = 10'(p10 >> Shift10);

    in_ready  = !valid_r || out_ready;
    valid_nxt = in_ready ? in_valid : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      quot_r <= quot_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_quot  = quot_r;

endmodule

// ===== hdl/sntdw_emit.sv =====
// Digit formation, result buffer and four-write serializer.
`timescale 1ns / 1ps

module sntdw_emit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  sntdw_pkg::quot_t  in_quot,
  output logic              out_valid,
  input  logic              out_ready,
  output sntdw_pkg::dreg_t  out_reg,
  output sntdw_pkg::digit_t out_code,
  output logic              out_last
);
  import sntdw_pkg::*;

  localparam logic [1:0] LastIdx = 2'(NumDigits - 1);

  logic       valid_r, valid_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  digit_t     dig_r [NumDigits];
  digit_t     dig_nxt [NumDigits];
  digit_t     d1, d2, d3;
  logic       last_beat;

  always_comb begin
    // remainders from neighboring quotients
    d1 = 4'(in_quot.q100 - 7'(in_quot.q1000) * 7'd10);
    d2 = 4'(in_quot.q10 - 10'(in_quot.q100) * 10'd10);
    d3 = 4'(in_quot.mag - MagW'(in_quot.q10) * MagW'(10));

    // blank leading zeros, units always shown
    dig_nxt[0] = (in_quot.q1000 == 4'd0) ? CodeBlank : in_quot.q1000;
    dig_nxt[1] = (in_quot.q100 == 7'd0) ? CodeBlank : d1;
    dig_nxt[2] = (in_quot.q10 == 10'd0) ? CodeBlank : d2;
    dig_nxt[3] = d3;

    // minus goes just left of the leading digit
    if (in_quot.neg) begin
      priority if (in_quot.q100 != 7'd0) begin
        dig_nxt[0] = CodeMinus;
      end else if (in_quot.q10 != 10'd0) begin
        dig_nxt[1] = CodeMinus;
      end else begin
        dig_nxt[2] = CodeMinus;
      end
    end

    last_beat = valid_r && out_ready && (cnt_r == LastIdx);
    in_ready  = !valid_r || last_beat;
    valid_nxt = in_ready ? in_valid : valid_r;
    // advance on each taken write, wrap after the last
    cnt_nxt   = (valid_r && out_ready) ? cnt_r + 2'd1 : cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      cnt_r   <= 2'd0;
    end else begin
      valid_r <= valid_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      for (int i = 0; i < NumDigits; i++) begin
        dig_r[i] <= dig_nxt[i];
      end
    end
  end

  assign out_valid = valid_r;
  assign out_reg   = dreg_t'(cnt_r) + FirstReg;
  assign out_code  = dig_r[cnt_r];
  assign out_last  = (cnt_r == LastIdx);

endmodule

// ===== hdl/sntdw_checker.sv =====
// Port checker for the digit write block, bound to the top level.
`timescale 1ns / 1ps
`include "signed_number_to_digit_writes_assert.svh"

module sntdw_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  // hold a stalled write
  `SNTDW_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled digit write changed")

  `SNTDW_ASSERT_IMP(a_reg_range, out_tvalid, (out_tdata[2:0] >= 3'd1) && (out_tdata[2:0] <= 3'd4) && !out_tdata[7], "digit register out of range")

  `SNTDW_ASSERT_IMP(a_last_reg4, out_tvalid, out_tlast == (out_tdata[2:0] == 3'd4), "tlast not on digit register 4")

  // writes of a run come in register order
  `SNTDW_ASSERT_NXT(a_reg_order, out_tvalid && out_tready && !out_tlast, out_tvalid && (out_tdata[2:0] == $past(out_tdata[2:0]) + 3'd1), "digit run broken")

  `SNTDW_ASSERT_IMP(a_code_legal, out_tvalid, (out_tdata[6:3] <= 4'd10) || (out_tdata[6:3] == 4'd15), "illegal digit code")

endmodule

bind signed_number_to_digit_writes sntdw_checker u_sntdw_checker (.*);

// ===== test/tb_signed_number_to_digit_writes.sv =====
// Testbench for the signed number to digit write block: predicted writes vs. stream output.
`timescale 1ns / 1ps

module tb_signed_number_to_digit_writes;
  import sntdw_pkg::*;

  localparam int QuietLimit = 2000;
  localparam int DrainCycles = 8;

  typedef struct packed {
    dreg_t  dreg;
    digit_t code;
    logic   last;
  } digit_write_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;   // [15:0] number_in
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;       // [2:0] digit_register, [6:3] digit_code, [7] zero
  logic        out_tlast;       // last_write

  digit_write_t expected_writes[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;

  always #4 clk = ~clk;

  signed_number_to_digit_writes u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // Append the four digit writes that a shown number produces.
  function automatic void queue_digit_writes(input logic signed [15:0] number);
    int           value;
    int           mag;
    logic         neg;
    digit_t       digits [NumDigits];
    digit_write_t w;
    if (number > NumMax || number < NumMin) return;
    value = number;
    neg = value < 0;
    mag = neg ? -value : value;
    digits[0] = digit_t'(mag / 1000);
    digits[1] = digit_t'((mag / 100) % 10);
    digits[2] = digit_t'((mag / 10) % 10);
    digits[3] = digit_t'(mag % 10);
    // blank leading zeros, keep units
    if (mag < 10) digits[2] = CodeBlank;
    if (mag < 100) digits[1] = CodeBlank;
    if (mag < 1000) digits[0] = CodeBlank;
    if (neg) begin
      if (mag > 99) digits[0] = CodeMinus;
      else if (mag > 9) digits[1] = CodeMinus;
      else digits[2] = CodeMinus;
    end
    for (int k = 0; k < NumDigits; k++) begin
      w.dreg = dreg_t'(FirstReg + k);
      w.code = digits[k];
      w.last = (k == NumDigits - 1);
      expected_writes.push_back(w);
    end
  endfunction

  function automatic logic [15:0] random_number();
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) return 16'($urandom);
    if (pick < 18) return ($urandom_range(1) == 0) ? 16'(10000 + $urandom_range(20))
                                                 : 16'(-1000 - int'($urandom_range(20)));
    if (pick < 45) return 16'(int'($urandom_range(240)) - 120);
    if (pick < 55) begin
      case ($urandom_range(5))
        0: return 16'(9999 - int'($urandom_range(3)));
        1: return 16'(-999 + int'($urandom_range(3)));
        2: return 16'(98 + int'($urandom_range(3)));
        3: return 16'(-101 + int'($urandom_range(3)));
        4: return 16'(999 + int'($urandom_range(2)));
        default: return 16'(-11 + int'($urandom_range(3)));
      endcase
    end
    return 16'(int'($urandom_range(10998)) - 999);
  endfunction

  // Send one request; called and returns at a rising edge.
  task automatic send_number(input logic signed [15:0] number);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct && gap < 40) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= number;
    do @(posedge clk); while (!in_tready);
    queue_digit_writes(number);
  endtask

  // Hold requests until every expected write has come back.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_writes.size() != 0) @(posedge clk);
  endtask

  task automatic run_random(input int count);
    repeat (count) send_number(random_number());
  endtask

  task automatic test_directed();
    int corner_numbers [25] = '{0, 1, 9, 10, 99, 100, 999, 1000, 9999, 10000, 32767,
                                -1, -9, -10, -99, -100, -999, -1000, -32768,
                                -21846, 21845, 1005, -505, -50, 7070};
    send_idle_pct = 0;
    recv_stall_pct = 0;
    foreach (corner_numbers[i]) send_number(16'(corner_numbers[i]));
    wait_drained();
  endtask

  task automatic test_no_idle();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    run_random(31);
    wait_drained();
  endtask

  task automatic test_sender_idle();
    send_idle_pct = 49;
    recv_stall_pct = 0;
    run_random(31);
    wait_drained();
  endtask

  task automatic test_receiver_stall();
    send_idle_pct = 0;
    recv_stall_pct = 49;
    run_random(31);
    wait_drained();
  endtask

  task automatic test_both_idle();
    send_idle_pct = 36;
    recv_stall_pct = 36;
    run_random(31);
    wait_drained();
  endtask

  // Compare each accepted write with the oldest prediction.
  always @(posedge clk) begin : take_writes
    digit_write_t want;
    if (out_tvalid && out_tready) begin
      if (expected_writes.size() == 0) begin
        $error("unexpected digit write: tdata %h, tlast %b", out_tdata, out_tlast);
        errors++;
      end else begin
        want = expected_writes.pop_front();
        if (out_tdata[2:0] !== want.dreg) begin
          $error("digit_register: expected %0d, got %0d", want.dreg, out_tdata[2:0]);
          errors++;
        end
        if (out_tdata[6:3] !== want.code) begin
          $error("digit_code: expected %0d, got %0d", want.code, out_tdata[6:3]);
          errors++;
        end
        if (out_tlast !== want.last) begin
          $error("last_write: expected %0d, got %0d", want.last, out_tlast);
          errors++;
        end
        if (out_tdata[7] !== 1'b0) begin
          $error("tdata pad: expected 0, got %b", out_tdata[7]);
          errors++;
        end
      end
    end
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QuietLimit) begin
      $display("signed_number_to_digit_writes test failed");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_no_idle();
    test_sender_idle();
    test_receiver_stall();
    test_both_idle();
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0) begin
      $display("signed_number_to_digit_writes test passed");
    end else begin
      $display("signed_number_to_digit_writes test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/sntdw_pkg.sv
hdl/sntdw_front.sv
hdl/sntdw_quot.sv
hdl/sntdw_emit.sv
hdl/signed_number_to_digit_writes.sv
hdl/sntdw_checker.sv
test/tb_signed_number_to_digit_writes.sv
